// File: rtl/bfbp_pkg.sv
// Shared types and constants for the best-fit block pool.
`timescale 1ns / 1ps
package bfbp_pkg;
	localparam int ADDR_W = 64;
	localparam int SIZE_W = 48;
	localparam int BYTES_W = 54;
	localparam int CFG_W = 13;
	localparam logic [CFG_W-1:0] MIN_SIZE_RESET = 13'd128;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PURGE   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_REUSED  = 3'd0,
		ST_NEW     = 3'd1,
		ST_RELEASED = 3'd2,
		ST_DOUBLE  = 3'd3,
		ST_UNKNOWN = 3'd4,
		ST_FULL    = 3'd5,
		ST_PURGED  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_FINISH,
		S_DONE
	} state_t;

	// Compare results from the shared entry unit.
	typedef struct packed {
		logic eq_size;
		logic fits;
		logic smaller;
		logic eq_addr;
	} cmp_t;
endpackage

// File: rtl/best_fit_block_pool_unit.sv
// Best-fit block pool: sequencer, entry table and shared compare unit.
// One request at a time; the table walk reads one entry per pass through the read, eval and finish states.
// in_ready is low while busy, and a held result keeps the sequencer waiting until it is taken.
// arst_n clears counters, hint and byte total and sets config to MIN_SIZE_RESET; table entries are unset.
`timescale 1ns / 1ps
module best_fit_block_pool_unit
	import bfbp_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [SIZE_W-1:0]  request_size,
	input  logic [ADDR_W-1:0]  address,
	input  logic [ADDR_W-1:0]  fresh_address,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ADDR_W-1:0]  block_address,
	output logic [2:0]         status,
	output logic [BYTES_W-1:0] pool_bytes_total
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [ADDR_W-1:0] mem_addr [TABLE_DEPTH];
	logic [SIZE_W-1:0] mem_size [TABLE_DEPTH];
	logic              mem_busy [TABLE_DEPTH];

	state_t state_q, state_d;
	logic [CFG_W-1:0] min_q;
	logic [CW-1:0] count_q, hint_q, idx_q, wr_q;
	logic [BYTES_W-1:0] bytes_q;
	op_t op_q;
	logic [SIZE_W-1:0] req_q, best_q;
	logic [ADDR_W-1:0] key_q, fresh_q;
	logic found_q, ff_seen_q;
	logic [CW-1:0] pick_q, ff_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [SIZE_W-1:0] rd_size_q;
	logic rd_busy_q;
	logic [ADDR_W-1:0] res_addr_q;
	status_t res_st_q;
	logic out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	status_t out_st_q;
	logic [BYTES_W-1:0] out_bytes_q;
	cmp_t cmp;

	logic [SIZE_W-1:0] req_raised;
	assign req_raised = (request_size < SIZE_W'(min_q)) ? SIZE_W'(min_q) : request_size;

	bfbp_cmp u_cmp (
		.entry_size(rd_size_q), .entry_addr(rd_addr_q), .req(req_q),
		.best_size(best_q), .key_addr(key_q), .cmp(cmp)
	);

	// walk is done when index leaves the table
	logic walk_end;
	always_comb begin
		if (op_q == OP_RELEASE) walk_end = (idx_q == '0);
		else walk_end = (idx_q >= count_q) || (idx_q >= DEPTH_C);
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign block_address = out_addr_q;
	assign status = out_st_q;
	assign pool_bytes_total = out_bytes_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = (operation == OP_NONE) ? S_DONE : S_FINISH;
			S_READ:   state_d = S_EVAL;
			S_EVAL:   state_d = S_FINISH;
			S_FINISH: state_d = walk_end ? S_DONE : S_READ;
			S_DONE:   if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// table reads: registered
	logic [IW-1:0] rd_idx;
	assign rd_idx = (op_q == OP_RELEASE) ? IW'(idx_q - 1'b1) : idx_q[IW-1:0];
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rd_addr_q <= mem_addr[rd_idx];
			rd_size_q <= mem_size[rd_idx];
			rd_busy_q <= mem_busy[rd_idx];
		end
	end

	logic wr_en;
	logic [IW-1:0] wr_idx;
	logic [ADDR_W-1:0] wr_addr;
	logic [SIZE_W-1:0] wr_size;
	logic wr_busy;
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_addr[wr_idx] <= wr_addr;
			mem_size[wr_idx] <= wr_size;
			mem_busy[wr_idx] <= wr_busy;
		end
	end

	// write port: purge copy in EVAL, final update in FINISH
	always_comb begin
		wr_en = 1'b0;
		wr_idx = wr_q[IW-1:0];
		wr_addr = rd_addr_q;
		wr_size = rd_size_q;
		wr_busy = 1'b1;
		if (state_q == S_EVAL && op_q == OP_PURGE && rd_busy_q) begin
			wr_en = 1'b1;
		end else if (state_q == S_FINISH && walk_end) begin
			case (op_q)
				OP_ALLOC: begin
					if (found_q) begin
						wr_en = 1'b1;
						wr_idx = pick_q[IW-1:0];
						wr_addr = res_addr_q;
						wr_size = best_q;
					end else if (count_q < DEPTH_C) begin
						wr_en = 1'b1;
						wr_idx = count_q[IW-1:0];
						wr_addr = fresh_q;
						wr_size = req_q;
					end
				end
				OP_RELEASE: begin
					if (found_q && res_st_q == ST_RELEASED) begin
						wr_en = 1'b1;
						wr_idx = pick_q[IW-1:0];
						wr_addr = key_q;
						wr_size = best_q;
						wr_busy = 1'b0;
					end
				end
				default: wr_en = 1'b0;
			endcase
		end
	end

	logic [CW-1:0] ff_fin;
	always_comb begin
		ff_fin = ff_q;
		if (!ff_seen_q) ff_fin = found_q ? pick_q : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_SIZE_RESET;
			count_q <= '0;
			hint_q <= '0;
			bytes_q <= '0;
			out_valid_q <= 1'b0;
			out_addr_q <= '0;
			out_st_q <= ST_REUSED;
			out_bytes_q <= '0;
			idx_q <= '0;
			wr_q <= '0;
			found_q <= 1'b0;
			ff_seen_q <= 1'b0;
			op_q <= OP_ALLOC;
		end else begin
			if (cfg_we) min_q <= cfg_wdata;
			// result register: loaded when the sequencer leaves S_DONE
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				out_addr_q <= res_addr_q;
				out_st_q <= res_st_q;
				out_bytes_q <= bytes_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_valid) begin
					op_q <= op_t'(operation);
					found_q <= 1'b0;
					ff_seen_q <= 1'b0;
					wr_q <= '0;
					res_addr_q <= '0;
					res_st_q <= ST_UNKNOWN;
					req_q <= req_raised;
					key_q <= address;
					fresh_q <= fresh_address;
					case (op_t'(operation))
						OP_ALLOC:   idx_q <= hint_q;
						OP_RELEASE: idx_q <= count_q;
						default:    idx_q <= '0;
					endcase
				end
				S_EVAL: begin
					case (op_q)
						OP_ALLOC: begin
							// exact match ends the walk
							idx_q <= (!rd_busy_q && cmp.eq_size) ? count_q : idx_q + 1'b1;
							if (!rd_busy_q) begin
								if (!ff_seen_q) begin
									ff_seen_q <= 1'b1;
									ff_q <= idx_q;
								end
								if (cmp.eq_size || (cmp.fits && (!found_q || cmp.smaller))) begin
									found_q <= 1'b1;
									pick_q <= idx_q;
									best_q <= rd_size_q;
									res_addr_q <= rd_addr_q;
								end
							end
						end
						OP_RELEASE: begin
							idx_q <= cmp.eq_addr ? '0 : idx_q - 1'b1;
							if (cmp.eq_addr) begin
								found_q <= 1'b1;
								pick_q <= idx_q - 1'b1;
								best_q <= rd_size_q;
								res_st_q <= rd_busy_q ? ST_RELEASED : ST_DOUBLE;
							end
						end
						default: begin
							idx_q <= idx_q + 1'b1;
							if (rd_busy_q) wr_q <= wr_q + 1'b1;
							else bytes_q <= bytes_q - BYTES_W'(rd_size_q);
						end
					endcase
				end
				S_FINISH: if (walk_end) begin
					case (op_q)
						OP_ALLOC: begin
							if (ff_fin > hint_q) hint_q <= ff_fin;
							if (found_q) res_st_q <= ST_REUSED;
							else if (count_q >= DEPTH_C) begin
								res_st_q <= ST_FULL;
								res_addr_q <= '0;
							end else begin
								res_st_q <= ST_NEW;
								res_addr_q <= fresh_q;
								count_q <= count_q + 1'b1;
								bytes_q <= bytes_q + BYTES_W'(req_q);
							end
						end
						OP_RELEASE: if (found_q && res_st_q == ST_RELEASED
							&& pick_q < hint_q) hint_q <= pick_q;
						default: begin
							res_st_q <= ST_PURGED;
							count_q <= wr_q;
							if (hint_q > wr_q) hint_q <= wr_q;
						end
					endcase
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C) else $error("entry count above depth");
	a_hint_range: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= count_q || (hint_q <= DEPTH_C)) else $error("hint out of range");
	a_busy_noaccept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(status))
		else $error("result dropped");
`endif
endmodule

// File: rtl/bfbp_cmp.sv
// Shared compare unit for one table entry against the current request.
`timescale 1ns / 1ps
module bfbp_cmp
	import bfbp_pkg::*;
(
	input  logic [SIZE_W-1:0] entry_size,
	input  logic [ADDR_W-1:0] entry_addr,
	input  logic [SIZE_W-1:0] req,
	input  logic [SIZE_W-1:0] best_size,
	input  logic [ADDR_W-1:0] key_addr,
	output cmp_t              cmp
);
	logic [SIZE_W:0] twice;
	assign twice = {req, 1'b0};
	always_comb begin
		cmp.eq_size = (entry_size == req);
		cmp.fits = (entry_size > req) && ({1'b0, entry_size} < twice);
		cmp.smaller = (entry_size < best_size);
		cmp.eq_addr = (entry_addr == key_addr);
	end
endmodule
